[src/sact_pkg.sv]
package sact_pkg;

  localparam int unsigned SetsDefault = 256;
  localparam int unsigned WaysDefault = 8;
  localparam int unsigned OffsetMax   = 12;
  localparam int unsigned SetBitsMax  = 8;
  localparam logic [15:0] LfsrSeed    = 16'hACE1;
  localparam logic [15:0] LfsrMask    = 16'hB400;

  typedef enum logic [2:0] {
    CfgOffsetBits   = 3'd0,
    CfgSetIndexBits = 3'd1,
    CfgWaysInUse    = 3'd2,
    CfgReplaceMode  = 3'd3,
    CfgWriteAlloc   = 3'd4
  } cfg_index_e;

  typedef enum logic [1:0] {
    ModeLru    = 2'd0,
    ModeFifo   = 2'd1,
    ModeRandom = 2'd2
  } replace_mode_e;

  typedef enum logic [1:0] {
    OutHit      = 2'd0,
    OutFill     = 2'd1,
    OutEvict    = 2'd2,
    OutNoAlloc  = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StResult
  } ctrl_state_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [7:0]  set_number;
    logic [31:0] tag_value;
    logic [2:0]  way_used;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } rsp_t;

  typedef struct packed {
    logic capture;  // latch request, launch memory read
    logic update;   // decide, write back, build result
  } dp_cmd_t;

endpackage

[src/sact_ctrl.sv]
module sact_ctrl
  import sact_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  output logic    rsp_valid_o,
  input  logic    rsp_ready_i,
  input  logic    dp_busy_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (req_valid_i && !dp_busy_i) state_d = StLookup;
      StLookup: state_d = StResult;
      StResult: if (rsp_ready_i) state_d = req_valid_i ? StLookup : StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // A new request may be taken in the cycle its predecessor's result leaves.
  always_comb begin
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      StIdle:   req_ready_o = !dp_busy_i;
      StLookup: cmd_o.update = 1'b1;
      StResult: begin
        rsp_valid_o = 1'b1;
        req_ready_o = rsp_ready_i;
      end
      default: ;
    endcase
    cmd_o.capture = req_ready_o & req_valid_i;
  end

endmodule

[src/sact_datapath.sv]
module sact_datapath
  import sact_pkg::*;
#(
  parameter int unsigned SETS = SetsDefault,
  parameter int unsigned WAYS = WaysDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  req_t        req_i,
  input  dp_cmd_t     cmd_i,
  output logic        busy_o,
  output rsp_t        rsp_o
);

  localparam int unsigned SetW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RecipShift = 20;

  logic [3:0] offset_bits_q, set_bits_q, ways_q;
  logic [1:0] mode_q;
  logic       walloc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= 4'd6;
      set_bits_q    <= 4'd8;
      ways_q        <= 4'd8;
      mode_q        <= ModeLru;
      walloc_q      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgOffsetBits:   offset_bits_q <= cfg_data_i;
        CfgSetIndexBits: set_bits_q    <= cfg_data_i;
        CfgWaysInUse:    ways_q        <= cfg_data_i;
        CfgReplaceMode:  mode_q        <= cfg_data_i[1:0];
        CfgWriteAlloc:   walloc_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Address split for the incoming request.
  logic [3:0]  off_c, sb_c;
  logic [4:0]  shift_c;
  logic [31:0] set_raw_c, tag_c;
  logic [SetW-1:0] set_c;
  logic [SetW-1:0] set_mod_tab [256];

  // The raw set index never exceeds 255, so a constant table folds it onto
  // the set store.
  for (genvar v = 0; v < 256; v++) begin : g_set_mod
    assign set_mod_tab[v] = SetW'(v % SETS);
  end

  always_comb begin
    off_c     = (offset_bits_q > 4'(OffsetMax)) ? 4'(OffsetMax) : offset_bits_q;
    sb_c      = (set_bits_q > 4'(SetBitsMax)) ? 4'(SetBitsMax) : set_bits_q;
    shift_c   = 5'(off_c) + 5'(sb_c);
    set_raw_c = (req_i.address >> off_c) & ((32'd1 << sb_c) - 32'd1);
    set_c     = set_mod_tab[set_raw_c[7:0]];
    tag_c     = req_i.address >> shift_c;
  end

  // Per-way memories: tag, stamp and valid, registered read.
  logic [31:0] tag_mem   [WAYS][SETS];
  logic [31:0] stamp_mem [WAYS][SETS];
  logic        valid_mem [WAYS][SETS];
  logic [31:0] tag_rd_q   [WAYS];
  logic [31:0] stamp_rd_q [WAYS];
  logic        valid_rd_q [WAYS];
  logic [WAYS-1:0] tag_we, stamp_we;

  logic [SetW-1:0] set_q;
  logic [7:0]      set_out_q;
  logic [31:0]     tag_q;
  logic            write_q;
  logic [WayW-1:0] rnd_way_q;

  logic [31:0] stamp_cnt_q, hits_q, misses_q;
  logic [15:0] lfsr_q, lfsr_n_c;
  logic            clr_busy_q;
  logic [SetW-1:0] clr_idx_q;
  logic [WAYS-1:0][3:0] rem_tab;

  // Decision over the registered row.
  logic [4:0]      ways_c;
  logic            hit_c, empty_c, found_c, alloc_c, rnd_c;
  logic [WayW-1:0] way_c, lru_c, pick_c;
  logic [31:0]     best_c;
  logic [1:0]      out_c;

  // After reset every set's valid bits are cleared, one set per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == SetW'(SETS - 1)) clr_busy_q <= 1'b0;
      clr_idx_q <= clr_idx_q + SetW'(1);
    end
  end

  assign busy_o = clr_busy_q;

  assign lfsr_n_c = (lfsr_q >> 1) ^ (lfsr_q[0] ? LfsrMask : 16'h0);

  // Remainder of the next LFSR value for every possible way count, by
  // reciprocal multiplication; exact for all 16-bit values.
  for (genvar d = 1; d <= WAYS; d++) begin : g_rem
    localparam logic [20:0] Recip = 21'(((1 << RecipShift) + d - 1) / d);
    logic [36:0] prod;
    logic [15:0] quo;
    assign prod = 37'(lfsr_n_c) * 37'(Recip);
    assign quo  = prod[35:20];
    assign rem_tab[d-1] = 4'(lfsr_n_c - quo * 16'(d));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      set_q     <= set_c;
      set_out_q <= 8'(set_c);
      tag_q     <= tag_c;
      write_q   <= req_i.opcode;
      rnd_way_q <= WayW'(rem_tab[WayW'(ways_c - 5'd1)]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int w = 0; w < WAYS; w++) begin
      if (cmd_i.capture) begin
        tag_rd_q[w]   <= tag_mem[w][set_c];
        stamp_rd_q[w] <= stamp_mem[w][set_c];
        valid_rd_q[w] <= valid_mem[w][set_c];
      end
      if (tag_we[w]) tag_mem[w][set_q] <= tag_q;
      if (stamp_we[w]) stamp_mem[w][set_q] <= stamp_cnt_q;
      if (clr_busy_q) valid_mem[w][clr_idx_q] <= 1'b0;
      else if (tag_we[w]) valid_mem[w][set_q] <= 1'b1;
    end
  end

  always_comb begin
    ways_c  = (ways_q == 4'd0) ? 5'd1 : 5'(ways_q);
    if (ways_c > 5'(WAYS)) ways_c = 5'(WAYS);
    rnd_c   = mode_q[1];
    alloc_c = !write_q || walloc_q;
    hit_c   = 1'b0;
    empty_c = 1'b0;
    found_c = 1'b0;
    way_c   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found_c && (5'(w) < ways_c)) begin
        if (!valid_rd_q[w]) begin
          found_c = 1'b1; empty_c = 1'b1; way_c = WayW'(w);
        end else if (tag_rd_q[w] == tag_q) begin
          found_c = 1'b1; hit_c = 1'b1; way_c = WayW'(w);
        end
      end
    end
    best_c = stamp_rd_q[0];
    lru_c  = '0;
    for (int w = 1; w < WAYS; w++) begin
      if ((5'(w) < ways_c) && (stamp_rd_q[w] < best_c)) begin
        best_c = stamp_rd_q[w];
        lru_c  = WayW'(w);
      end
    end
    if (hit_c) begin
      out_c = OutHit; pick_c = way_c;
    end else if (!alloc_c) begin
      out_c = OutNoAlloc; pick_c = '0;
    end else if (empty_c) begin
      out_c = OutFill; pick_c = way_c;
    end else begin
      out_c = OutEvict; pick_c = rnd_c ? rnd_way_q : lru_c;
    end
    tag_we   = '0;
    stamp_we = '0;
    if (cmd_i.update) begin
      if (!hit_c && alloc_c) tag_we[pick_c] = 1'b1;
      if ((hit_c && mode_q == ModeLru) || (!hit_c && alloc_c && !rnd_c))
        stamp_we[pick_c] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_cnt_q <= 32'd1;
      lfsr_q      <= LfsrSeed;
      hits_q      <= '0;
      misses_q    <= '0;
    end else if (cmd_i.update) begin
      if (|stamp_we) stamp_cnt_q <= stamp_cnt_q + 32'd1;
      if (hit_c) hits_q <= hits_q + 32'd1;
      else misses_q <= misses_q + 32'd1;
      if (!hit_c && alloc_c && !empty_c && rnd_c) lfsr_q <= lfsr_n_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rsp_o.outcome    <= out_c;
      rsp_o.set_number <= set_out_q;
      rsp_o.tag_value  <= tag_q;
      rsp_o.way_used   <= 3'(pick_c);
      rsp_o.hit_total  <= hit_c ? hits_q + 32'd1 : hits_q;
      rsp_o.miss_total <= hit_c ? misses_q : misses_q + 32'd1;
    end
  end

endmodule

[src/set_assoc_cache_tag_lookup.sv]
// Tag-only set-associative cache lookup.
// Requests (opcode, address) arrive on req_valid_i/req_ready_o; one result
// per request leaves on rsp_valid_o/rsp_ready_i, in order.
// The configuration port writes one register per cycle at cfg_we_i; it is to be
// used only while no request is outstanding, which the block does not enforce.
// An accepted request passes through the lookup state, where the registered
// row is decided and written back, to the result state, which raises rsp_valid_o.
// The per-way tag, stamp and valid memories each have a single read port and
// are written back in the lookup state, where no request is taken; a new
// request is accepted in the cycle the previous result is taken.
// If the receiver stalls, the result is held and no request is accepted.
// Reset clears the hit and miss counters, sets the stamp counter to one and the
// random generator to its seed, and restores register defaults. A clearing pass
// over every set then zeroes the valid memories, and no request is accepted until
// it ends; tag and stamp memories hold no meaning until written.
module set_assoc_cache_tag_lookup
  import sact_pkg::*;
#(
  parameter int unsigned SETS = SetsDefault,
  parameter int unsigned WAYS = WaysDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [3:0] cfg_data_i,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  req_t       req_i,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output rsp_t       rsp_o
);

  dp_cmd_t cmd;
  logic    dp_busy;

  sact_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i,
    .dp_busy_i (dp_busy),
    .cmd_o     (cmd)
  );

  sact_datapath #(.SETS(SETS), .WAYS(WAYS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .req_i,
    .cmd_i (cmd), .busy_o (dp_busy), .rsp_o
  );

endmodule

[src/sact_checker.sv]
module sact_checker
  import sact_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_o,
  input logic rsp_valid_o,
  input logic rsp_ready_i,
  input rsp_t rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed while stalled");

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !rsp_valid_o ##1 rsp_valid_o)
    else $error("result not two cycles after request");

  a_no_take_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |-> !req_ready_o)
    else $error("request taken while result stalled");

  a_way_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.outcome == OutNoAlloc |-> rsp_o.way_used == 3'd0)
    else $error("way reported without allocation");

endmodule

bind set_assoc_cache_tag_lookup sact_checker u_sact_checker (
  .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i, .rsp_o
);

[test/tb_set_assoc_cache_tag_lookup.sv]
module tb_set_assoc_cache_tag_lookup;
  import sact_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSets = SetsDefault;
  localparam int unsigned NWays = WaysDefault;
  localparam logic [2:0] CfgUnused = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [3:0] cfg_data;
  logic req_valid;
  logic req_ready;
  req_t req_data;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp_data;

  set_assoc_cache_tag_lookup #(.SETS(NSets), .WAYS(NWays)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req_data),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp_data)
  );

  // Predictor state.
  logic [3:0]  pr_offset_bits;
  logic [3:0]  pr_set_bits;
  logic [3:0]  pr_ways;
  logic [1:0]  pr_mode;
  logic        pr_walloc;
  logic [31:0] pr_tags [NSets*NWays];
  bit          pr_valid [NSets*NWays];
  logic [31:0] pr_stamps [NSets*NWays];
  logic [31:0] pr_stamp_ctr;
  logic [15:0] pr_lfsr;
  logic [31:0] pr_hits;
  logic [31:0] pr_misses;

  rsp_t expected_rsp [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned requests_sent;
  bit quiet_period;
  int unsigned rsp_hold_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned eff_offset();
    return (pr_offset_bits > OffsetMax) ? OffsetMax : pr_offset_bits;
  endfunction

  function automatic int unsigned eff_set_bits();
    return (pr_set_bits > SetBitsMax) ? SetBitsMax : pr_set_bits;
  endfunction

  function automatic int unsigned eff_ways();
    int unsigned w;
    w = (pr_ways == 0) ? 1 : pr_ways;
    return (w > NWays) ? NWays : w;
  endfunction

  task automatic reset_predictor();
    pr_offset_bits = 4'd6;
    pr_set_bits    = 4'd8;
    pr_ways        = 4'd8;
    pr_mode        = ModeLru;
    pr_walloc      = 1'b1;
    foreach (pr_valid[i]) pr_valid[i] = 1'b0;
    pr_stamp_ctr = 32'd1;
    pr_lfsr      = LfsrSeed;
    pr_hits      = '0;
    pr_misses    = '0;
  endtask

  task automatic stamp_slot(input int unsigned slot);
    pr_stamps[slot] = pr_stamp_ctr;
    pr_stamp_ctr    = pr_stamp_ctr + 32'd1;
  endtask

  task automatic predict_lookup(input req_t r);
    int unsigned off, sb, ways, set, base, way, slot;
    logic [31:0] tag, best;
    bit hit, has_empty, alloc, rnd;
    rsp_t e;
    off  = eff_offset();
    sb   = eff_set_bits();
    ways = eff_ways();
    set  = ((r.address >> off) & ((32'd1 << sb) - 32'd1)) % NSets;
    tag  = r.address >> (off + sb);
    base = set * NWays;
    hit = 1'b0;
    has_empty = 1'b0;
    way = 0;
    alloc = !r.opcode || pr_walloc;
    rnd = pr_mode >= ModeRandom;
    for (int unsigned w = 0; w < ways; w++) begin
      if (!pr_valid[base+w]) begin
        has_empty = 1'b1;
        way = w;
        break;
      end
      if (pr_tags[base+w] == tag) begin
        hit = 1'b1;
        way = w;
        break;
      end
    end
    if (hit) begin
      e.outcome = OutHit;
      pr_hits = pr_hits + 32'd1;
      if (pr_mode == ModeLru) stamp_slot(base + way);
    end else begin
      pr_misses = pr_misses + 32'd1;
      if (!alloc) begin
        e.outcome = OutNoAlloc;
        way = 0;
      end else begin
        if (has_empty) begin
          e.outcome = OutFill;
        end else begin
          e.outcome = OutEvict;
          if (rnd) begin
            pr_lfsr = pr_lfsr[0] ? ((pr_lfsr >> 1) ^ LfsrMask) : (pr_lfsr >> 1);
            way = pr_lfsr % ways;
          end else begin
            best = pr_stamps[base];
            way = 0;
            for (int unsigned w = 1; w < ways; w++) begin
              if (pr_stamps[base+w] < best) begin
                best = pr_stamps[base+w];
                way = w;
              end
            end
          end
        end
        slot = base + way;
        pr_tags[slot]  = tag;
        pr_valid[slot] = 1'b1;
        if (!rnd) stamp_slot(slot);
      end
    end
    e.set_number = set[7:0];
    e.tag_value  = tag;
    e.way_used   = way[2:0];
    e.hit_total  = pr_hits;
    e.miss_total = pr_misses;
    expected_rsp.push_back(e);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_valid && rsp_ready) begin
      results_seen++;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp_data);
      end else begin
        e = expected_rsp.pop_front();
        if (rsp_data.outcome !== e.outcome || rsp_data.set_number !== e.set_number ||
            rsp_data.tag_value !== e.tag_value || rsp_data.way_used !== e.way_used ||
            rsp_data.hit_total !== e.hit_total || rsp_data.miss_total !== e.miss_total) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected outcome %0d set %0d tag %h way %0d hits %0d misses %0d",
                     e.outcome, e.set_number, e.tag_value, e.way_used, e.hit_total,
                     e.miss_total);
            $display("  actual   outcome %0d set %0d tag %h way %0d hits %0d misses %0d",
                     rsp_data.outcome, rsp_data.set_number, rsp_data.tag_value,
                     rsp_data.way_used, rsp_data.hit_total, rsp_data.miss_total);
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (rsp_hold_left > 0) begin
      rsp_ready <= 1'b0;
      rsp_hold_left <= rsp_hold_left - 1;
    end else begin
      rsp_ready <= quiet_period ? 1'b1 : ($urandom_range(99) >= 28);
    end
  end

  task automatic send_request(input logic op, input logic [31:0] addr);
    @(negedge clk_i);
    if (!quiet_period) begin
      while ($urandom_range(99) < 28) begin
        req_valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    req_valid <= 1'b1;
    req_data.opcode <= op;
    req_data.address <= addr;
    do @(posedge clk_i); while (!req_ready);
    predict_lookup('{opcode: op, address: addr});
    requests_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CfgOffsetBits:   pr_offset_bits = val;
      CfgSetIndexBits: pr_set_bits = val;
      CfgWaysInUse:    pr_ways = val;
      CfgReplaceMode:  pr_mode = val[1:0];
      CfgWriteAlloc:   pr_walloc = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [3:0] off, input logic [3:0] sb, input logic [3:0] ways,
                           input logic [1:0] mode, input logic walloc);
    wait_drained();
    write_reg(CfgOffsetBits, off);
    write_reg(CfgSetIndexBits, sb);
    write_reg(CfgWaysInUse, ways);
    write_reg(CfgReplaceMode, {2'($urandom_range(3)), mode});
    write_reg(CfgWriteAlloc, {3'($urandom_range(7)), walloc});
  endtask

  function automatic logic [31:0] make_addr(input logic [31:0] tag, input int unsigned set,
                                            input logic [31:0] low);
    int unsigned off, sb;
    off = eff_offset();
    sb  = eff_set_bits();
    return (tag << (off + sb)) | ((set & ((1 << sb) - 1)) << off) |
           (low & ((32'd1 << off) - 32'd1));
  endfunction

  // Mostly accesses to a handful of tags in a few sets, so that sets fill,
  // hit and evict; the rest are fully random addresses.
  task automatic run_random_traffic(input int unsigned n);
    logic [31:0] tag_pool [10];
    int unsigned set_pool [3];
    logic [31:0] addr;
    foreach (tag_pool[i]) tag_pool[i] = $urandom();
    foreach (set_pool[i]) set_pool[i] = $urandom_range(255);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) addr = $urandom();
      else addr = make_addr(tag_pool[$urandom_range(9)], set_pool[$urandom_range(2)],
                            $urandom());
      send_request($urandom_range(1), addr);
    end
  endtask

  task automatic test_directed_defaults();
    send_request(1'b0, 32'h0000_0000);
    send_request(1'b0, 32'h0000_0000);
    send_request(1'b1, 32'hFFFF_FFFF);
    send_request(1'b0, 32'h0000_003F);
    send_request(1'b1, 32'hFFFF_FFC0);
    for (int unsigned t = 1; t <= 9; t++) send_request(t[0], t << 14);
    send_request(1'b1, 32'h0000_0000);
    configure(4'd6, 4'd8, 4'd8, ModeLru, 1'b0);
    send_request(1'b1, 32'h0004_0000);
    send_request(1'b1, 32'h0000_4000);
    send_request(1'b0, 32'h0004_0000);
    wait_drained();
    write_reg(CfgUnused, 4'hF);
  endtask

  task automatic test_lru_fifo_geometries();
    configure(4'd0, 4'd0, 4'd1, ModeLru, 1'b1);
    run_random_traffic(200);
    configure(4'd12, 4'd8, 4'd8, ModeFifo, 1'b1);
    run_random_traffic(200);
    configure(4'd15, 4'd15, 4'd15, ModeLru, 1'b0);
    run_random_traffic(200);
    configure(4'd4, 4'd3, 4'd0, ModeFifo, 1'b0);
    run_random_traffic(200);
    configure(4'd2, 4'd2, 4'd4, ModeLru, 1'b1);
    run_random_traffic(200);
    configure(4'd2, 4'd2, 4'd8, ModeFifo, 1'b1);
    run_random_traffic(150);
  endtask

  // Random replacement runs after the LRU and FIFO tests: its fills leave stamps unwritten.
  task automatic test_random_replacement();
    configure(4'd5, 4'd2, 4'd8, ModeRandom, 1'b1);
    run_random_traffic(200);
    configure(4'd13, 4'd1, 4'd5, 2'd3, 1'b0);
    run_random_traffic(150);
  endtask

  task automatic test_backpressure();
    configure(4'd3, 4'd1, 4'd3, ModeRandom, 1'b1);
    quiet_period = 1'b1;
    run_random_traffic(100);
    @(negedge clk_i);
    rsp_hold_left = 300;
    run_random_traffic(60);
    quiet_period = 1'b0;
    run_random_traffic(100);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgOffsetBits;
    cfg_data = '0;
    req_valid = 1'b0;
    req_data = '0;
    rsp_ready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    requests_sent = 0;
    quiet_period = 1'b0;
    rsp_hold_left = 0;
    reset_predictor();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_defaults();
    test_lru_fifo_geometries();
    test_random_replacement();
    test_backpressure();
    wait_drained();

    if (expected_rsp.size() != 0) mismatches++;
    $display("Ran %0d requests, %0d results checked, %0d hits and %0d misses predicted.",
             requests_sent, results_seen, pr_hits, pr_misses);
    $display("Covered LRU, FIFO and random replacement, no-allocate writes and odd widths.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
